@@ rtl/status_led_colour_renderer_macros.svh @@
// assertion macros for the status led colour renderer
`ifndef STATUS_LED_COLOUR_RENDERER_MACROS_SVH
`define STATUS_LED_COLOUR_RENDERER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SLCR_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slcr check failed");

// consequent must hold in the cycle after the antecedent
`define SLCR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slcr check failed");

`endif

@@ rtl/slcr_pkg.sv @@
// shared types, codes and constants of the status led colour renderer
`default_nettype none

package slcr_pkg;

    // field widths
    localparam int unsigned COLOUR_W = 24;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 12;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned K_W      = 9;
    localparam int unsigned PROD_W   = BYTE_W + K_W;
    localparam int unsigned STEP_W   = $clog2(TIME_W);

    // operation codes
    localparam logic [1:0] OP_RENDER      = 2'd0;
    localparam logic [1:0] OP_SET_PULSE   = 2'd1;
    localparam logic [1:0] OP_CLEAR_PULSE = 2'd2;

    // mode codes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_CONFIG  = 2'd1;
    localparam logic [1:0] MODE_UPDATE  = 2'd2;
    localparam logic [1:0] MODE_FACTORY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CONFIG_COLOUR  = 2'd0;
    localparam logic [1:0] REG_UPDATE_COLOUR  = 2'd1;
    localparam logic [1:0] REG_FACTORY_COLOUR = 2'd2;
    localparam logic [1:0] REG_WIFI_COLOUR    = 2'd3;

    // configuration reset values
    localparam logic [COLOUR_W-1:0] CONFIG_COLOUR_RST  = 24'hFF00FF;
    localparam logic [COLOUR_W-1:0] UPDATE_COLOUR_RST  = 24'h00FFFF;
    localparam logic [COLOUR_W-1:0] FACTORY_COLOUR_RST = 24'hFFFFFF;
    localparam logic [COLOUR_W-1:0] WIFI_COLOUR_RST    = 24'hFFC000;

    // colour channel codes for the breathe sequence
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    // timing constants in milliseconds
    localparam int unsigned SLOT_LEN    = 1000;
    localparam int unsigned GAP_LEN     = 200;
    localparam int unsigned CYCLE_LEN   = 2 * SLOT_LEN + 2 * GAP_LEN;
    localparam int unsigned SLOW_PERIOD = 500;
    localparam int unsigned FAST_PERIOD = 250;
    localparam int unsigned BREATHE_DIV = 500;

    // divide by BREATHE_DIV as a shift by two and a reciprocal multiply
    localparam int unsigned BR_PRE    = 2;
    localparam int unsigned BR_SHIFT  = 22;
    localparam int unsigned BR_DIV4   = BREATHE_DIV / 4;
    localparam int unsigned BR_RECIP  = (2 ** BR_SHIFT + BR_DIV4 - 1) / BR_DIV4;
    localparam int unsigned RECIP_W   = 16;
    localparam int unsigned SCALED_W  = PROD_W - BR_PRE + RECIP_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       set_pulse;
        logic       clear_pulse;
        logic       div_step;
        logic       eval;
        logic       br_mul;
        logic       br_scale;
        logic [1:0] chan;
        logic       out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic breathe;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/slcr_ctrl.sv @@
// sequencing controller of the status led colour renderer
`default_nettype none

module slcr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_op,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire slcr_pkg::status_t status,
    output slcr_pkg::cmd_t         cmd
);
    import slcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_MUL,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_cnt_reg, step_cnt_next;
    logic [1:0]          chan_reg, chan_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        chan_next     = chan_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        cmd.chan      = chan_reg;
        s_ready       = (state_reg == ST_IDLE);
        accept        = s_valid && s_ready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load        = accept && (s_op == OP_RENDER);
                cmd.set_pulse   = accept && (s_op == OP_SET_PULSE);
                cmd.clear_pulse = accept && (s_op == OP_CLEAR_PULSE);
                if (cmd.load) begin
                    state_next    = ST_DIV;
                    step_cnt_next = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(TIME_W - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.breathe) begin
                    chan_next  = CH_BLUE;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                cmd.br_mul = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.br_scale = 1'b1;
                if (chan_reg == CH_RED) begin
                    state_next = ST_OUT;
                end else begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            chan_reg     <= CH_BLUE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            chan_reg     <= chan_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ rtl/slcr_dp.sv @@
// datapath: registers, serial remainder unit, colour selection and breathe scaling
`default_nettype none

module slcr_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire slcr_pkg::cmd_t                 cmd,
    output slcr_pkg::status_t                   status,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [slcr_pkg::COLOUR_W-1:0]  cfg_wdata,
    input  wire logic                           cfg_we,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_now_ms,
    input  wire logic [slcr_pkg::COLOUR_W-1:0]  s_pulse_colour,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_pulse_on_ms,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_pulse_off_ms,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_pulse_duration_ms,
    input  wire logic [1:0]                     s_current_mode,
    input  wire logic [1:0]                     s_requested_mode,
    input  wire logic                           s_radio_enabled,
    input  wire logic                           s_access_point_up,
    input  wire logic                           s_access_point_client,
    input  wire logic                           s_network_hunting,
    output logic [slcr_pkg::COLOUR_W-1:0]       m_led_colour
);
    import slcr_pkg::*;

    // configuration registers
    logic [COLOUR_W-1:0] config_colour_reg;
    logic [COLOUR_W-1:0] update_colour_reg;
    logic [COLOUR_W-1:0] factory_colour_reg;
    logic [COLOUR_W-1:0] wifi_colour_reg;

    // held pulse
    logic [COLOUR_W-1:0] held_colour_reg;
    logic [TIME_W-1:0]   held_on_reg;
    logic [TIME_W-1:0]   held_off_reg;
    logic [TIME_W-1:0]   held_start_reg;
    logic [TIME_W-1:0]   held_expiry_reg;

    // captured render beat
    logic [1:0] cur_reg, req_reg;
    logic       radio_reg, ap_reg, client_reg, hunt_reg;
    logic       active_reg;

    // serial remainder unit
    logic [TIME_W-1:0] dividend_reg;
    logic [TIME_W:0]   divisor_reg;
    logic [TIME_W:0]   rem_reg;
    logic [TIME_W+1:0] trial;
    logic              load_active;

    // evaluation and breathe
    logic [COLOUR_W-1:0] eval_colour;
    logic                eval_breathe;
    logic [SLOT_W-1:0]   eval_p;
    logic [SLOT_W-1:0]   p_mirror;
    logic [K_W-1:0]      eval_k;
    logic [PHASE_W-1:0]  phase;
    logic [PHASE_W-1:0]  wphase;
    logic [PHASE_W-1:0]  slow_phase;
    logic [COLOUR_W-1:0] req_colour;
    logic [COLOUR_W-1:0] colour_reg;
    logic [K_W-1:0]      k_reg;
    logic [BYTE_W-1:0]   chan_byte;
    logic [PROD_W-1:0]   prod_reg;
    logic [SCALED_W-1:0] scaled;
    logic [BYTE_W-1:0]   quot;
    logic [COLOUR_W-1:0] acc_reg;
    logic [COLOUR_W-1:0] led_colour_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            config_colour_reg  <= CONFIG_COLOUR_RST;
            update_colour_reg  <= UPDATE_COLOUR_RST;
            factory_colour_reg <= FACTORY_COLOUR_RST;
            wifi_colour_reg    <= WIFI_COLOUR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CONFIG_COLOUR:  config_colour_reg  <= cfg_wdata;
                REG_UPDATE_COLOUR:  update_colour_reg  <= cfg_wdata;
                REG_FACTORY_COLOUR: factory_colour_reg <= cfg_wdata;
                REG_WIFI_COLOUR:    wifi_colour_reg    <= cfg_wdata;
                default:            config_colour_reg  <= config_colour_reg;
            endcase
        end
    end

    // pulse set and clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_colour_reg <= '0;
            held_on_reg     <= '0;
            held_off_reg    <= '0;
            held_start_reg  <= '0;
            held_expiry_reg <= '0;
        end else if (cmd.set_pulse) begin
            held_colour_reg <= s_pulse_colour;
            held_on_reg     <= s_pulse_on_ms;
            held_off_reg    <= s_pulse_off_ms;
            held_start_reg  <= s_now_ms;
            held_expiry_reg <= s_now_ms + s_pulse_duration_ms;
        end else if (cmd.clear_pulse) begin
            held_expiry_reg <= '0;
        end
    end

    // divider step: shift in one dividend bit, subtract when it fits
    assign load_active = (s_now_ms < held_expiry_reg);
    assign trial       = {rem_reg, dividend_reg[TIME_W-1]};

    // capture the render beat and run the remainder unit
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg    <= s_current_mode;
            req_reg    <= s_requested_mode;
            radio_reg  <= s_radio_enabled;
            ap_reg     <= s_access_point_up;
            client_reg <= s_access_point_client;
            hunt_reg   <= s_network_hunting;
            active_reg <= load_active;
            rem_reg    <= '0;
            if (load_active) begin
                dividend_reg <= s_now_ms - held_start_reg;
                divisor_reg  <= {1'b0, held_on_reg} + {1'b0, held_off_reg};
            end else begin
                dividend_reg <= s_now_ms;
                if (s_requested_mode != MODE_NORMAL) begin
                    divisor_reg <= (TIME_W+1)'(FAST_PERIOD);
                end else begin
                    divisor_reg <= (TIME_W+1)'(CYCLE_LEN);
                end
            end
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg}) begin
                rem_reg <= (TIME_W+1)'(trial - {1'b0, divisor_reg});
            end else begin
                rem_reg <= trial[TIME_W:0];
            end
        end
    end

    // tint of the pending request
    always_comb begin
        case (req_reg)
            MODE_CONFIG: req_colour = config_colour_reg;
            MODE_UPDATE: req_colour = update_colour_reg;
            default:     req_colour = factory_colour_reg;
        endcase
    end

    // precedence: pulse, then request, then the display cycle
    always_comb begin
        eval_colour  = '0;
        eval_breathe = 1'b0;
        eval_p       = '0;
        phase        = rem_reg[PHASE_W-1:0];
        wphase       = phase - PHASE_W'(SLOT_LEN + GAP_LEN);
        slow_phase   = (wphase >= PHASE_W'(SLOW_PERIOD)) ?
                       wphase - PHASE_W'(SLOW_PERIOD) : wphase;
        if (active_reg) begin
            if (held_off_reg == '0 || rem_reg < {1'b0, held_on_reg}) begin
                eval_colour = held_colour_reg;
            end
        end else if (req_reg != MODE_NORMAL) begin
            if (rem_reg < (TIME_W+1)'(FAST_PERIOD / 2)) begin
                eval_colour = req_colour;
            end
        end else if (phase < PHASE_W'(SLOT_LEN)) begin
            eval_p = phase[SLOT_W-1:0];
            if (cur_reg == MODE_CONFIG) begin
                eval_colour  = config_colour_reg;
                eval_breathe = 1'b1;
            end else if (cur_reg == MODE_UPDATE) begin
                eval_colour  = update_colour_reg;
                eval_breathe = 1'b1;
            end
        end else if (phase >= PHASE_W'(SLOT_LEN + GAP_LEN) &&
                     phase < PHASE_W'(2 * SLOT_LEN + GAP_LEN)) begin
            eval_p = wphase[SLOT_W-1:0];
            if (radio_reg) begin
                if (ap_reg) begin
                    eval_colour  = wifi_colour_reg;
                    eval_breathe = !client_reg;
                end else if (hunt_reg && slow_phase < PHASE_W'(SLOW_PERIOD / 2)) begin
                    eval_colour = wifi_colour_reg;
                end
            end
        end
    end

    // breathe envelope k = min(p, slot - p)
    assign p_mirror = SLOT_W'(SLOT_LEN) - eval_p;
    assign eval_k   = (eval_p < p_mirror) ? eval_p[K_W-1:0] : p_mirror[K_W-1:0];
    assign status.breathe = eval_breathe;

    // channel picked for the current breathe step
    always_comb begin
        case (cmd.chan)
            CH_BLUE:  chan_byte = colour_reg[BYTE_W-1:0];
            CH_GREEN: chan_byte = colour_reg[2*BYTE_W-1:BYTE_W];
            CH_RED:   chan_byte = colour_reg[3*BYTE_W-1:2*BYTE_W];
            default:  chan_byte = '0;
        endcase
    end

    // floor(prod / 500) as floor((prod >> 2) * recip >> shift)
    assign scaled = SCALED_W'(prod_reg[PROD_W-1:BR_PRE]) * SCALED_W'(BR_RECIP);
    assign quot   = scaled[BR_SHIFT +: BYTE_W];

    // evaluation, breathe scaling and result register
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            colour_reg <= eval_colour;
            k_reg      <= eval_k;
            acc_reg    <= eval_colour;
        end
        if (cmd.br_mul) begin
            prod_reg <= PROD_W'(chan_byte) * PROD_W'(k_reg);
        end
        if (cmd.br_scale) begin
            case (cmd.chan)
                CH_BLUE:  acc_reg[BYTE_W-1:0]          <= quot;
                CH_GREEN: acc_reg[2*BYTE_W-1:BYTE_W]   <= quot;
                default:  acc_reg[3*BYTE_W-1:2*BYTE_W] <= quot;
            endcase
        end
        if (cmd.out_load) begin
            led_colour_reg <= acc_reg;
        end
    end

    assign m_led_colour = led_colour_reg;

endmodule

`default_nettype wire

@@ rtl/status_led_colour_renderer.sv @@
// Render beat: accept, the 32-step remainder unit, evaluation, per-channel breathe
// scaling when the tint breathes, output load; only then is the next beat accepted.
// Set and clear pulse beats act on accept; the next beat is accepted right after.
// A finished result sits in the output register while the next beat is accepted.
// Synchronous active-low reset: registers to default tints, pulse cleared, idle.
`default_nettype none

`include "status_led_colour_renderer_macros.svh"

module status_led_colour_renderer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [slcr_pkg::COLOUR_W-1:0]  cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_op,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_now_ms,
    input  wire logic [slcr_pkg::COLOUR_W-1:0]  s_pulse_colour,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_pulse_on_ms,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_pulse_off_ms,
    input  wire logic [slcr_pkg::TIME_W-1:0]    s_pulse_duration_ms,
    input  wire logic [1:0]                     s_current_mode,
    input  wire logic [1:0]                     s_requested_mode,
    input  wire logic                           s_radio_enabled,
    input  wire logic                           s_access_point_up,
    input  wire logic                           s_access_point_client,
    input  wire logic                           s_network_hunting,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [slcr_pkg::COLOUR_W-1:0]       m_led_colour
);
    import slcr_pkg::*;

    cmd_t    ctrl_cmd;
    status_t dp_status;

    // controller
    slcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // datapath
    slcr_dp u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (ctrl_cmd),
        .status                (dp_status),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .cfg_we                (cfg_we),
        .s_now_ms              (s_now_ms),
        .s_pulse_colour        (s_pulse_colour),
        .s_pulse_on_ms         (s_pulse_on_ms),
        .s_pulse_off_ms        (s_pulse_off_ms),
        .s_pulse_duration_ms   (s_pulse_duration_ms),
        .s_current_mode        (s_current_mode),
        .s_requested_mode      (s_requested_mode),
        .s_radio_enabled       (s_radio_enabled),
        .s_access_point_up     (s_access_point_up),
        .s_access_point_client (s_access_point_client),
        .s_network_hunting     (s_network_hunting),
        .m_led_colour          (m_led_colour)
    );

    // checks
    `SLCR_ASSERT_NOW(a_no_result_overwrite, aclk, aresetn, ctrl_cmd.out_load, !m_valid || m_ready)
    `SLCR_ASSERT_NOW(a_busy_while_dividing, aclk, aresetn, ctrl_cmd.div_step, !s_ready)
    `SLCR_ASSERT_NEXT(a_render_starts_div, aclk, aresetn, s_valid && s_ready && s_op == OP_RENDER, ctrl_cmd.div_step)

endmodule

`default_nettype wire
